/* rtl/assert_macros.svh */
// Assertion helper macros for the RTL (included by wlf_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define WLF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wlf check failed");

// Next-cycle implication, disabled while reset is high
`define WLF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wlf check failed");

`endif

/* rtl/wlf_pkg.sv */
// Package: shared types and constants of the weight-limited FIFO
`timescale 1ns / 1ps

package wlf_pkg;

  localparam int WEIGHT_BITS = 14;
  localparam logic [WEIGHT_BITS-1:0] LIMIT_RESET = 14'd32;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_WEIGHT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  typedef struct packed {
    logic    valid;
    logic    pop_ok;
    status_t status;
  } stage_meta_t;

endpackage

/* rtl/wlf_cmd_if.sv */
// Interface: command channel (push or pop beats)
`timescale 1ns / 1ps

interface wlf_cmd_if #(
  parameter int ITEM_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [ITEM_BITS-1:0] item_value;

  modport source (output valid, command, item_value, input ready);
  modport sink   (input valid, command, item_value, output ready);
endinterface

/* rtl/wlf_rsp_if.sv */
// Interface: response channel (one beat per command)
`timescale 1ns / 1ps

interface wlf_rsp_if
  import wlf_pkg::*;
#(
  parameter int ITEM_BITS  = 8,
  parameter int COUNT_BITS = 7
);
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [ITEM_BITS-1:0]   popped_value;
  logic [COUNT_BITS-1:0]  entry_count;
  logic [WEIGHT_BITS-1:0] total_weight;

  modport source (output valid, status, popped_value, entry_count, total_weight,
                  input ready);
  modport sink   (input valid, status, popped_value, entry_count, total_weight,
                  output ready);
endinterface

/* rtl/wlf_store.sv */
// Item store: single-port-write, registered-read ring memory
`timescale 1ns / 1ps

module wlf_store
  import wlf_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int ITEM_BITS = 8,
  localparam int PTR_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  store_ctl_t           ctl,
  input  logic [PTR_W-1:0]     wr_addr,
  input  logic [PTR_W-1:0]     rd_addr,
  input  logic [ITEM_BITS-1:0] wr_data,
  output logic [ITEM_BITS-1:0] rd_data
);

  logic [ITEM_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/wlf_ctrl.sv */
// Control: admission, pointers, count, weight sum and the first result stage
`timescale 1ns / 1ps

module wlf_ctrl
  import wlf_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int ITEM_BITS = 8,
  localparam int PTR_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   limit_we,
  input  logic [WEIGHT_BITS-1:0] limit_wdata,
  wlf_cmd_if.sink                cmd,
  output store_ctl_t             store_ctl,
  output logic [PTR_W-1:0]       wr_ptr,
  output logic [PTR_W-1:0]       rd_ptr,
  input  logic [ITEM_BITS-1:0]   rd_data,
  output stage_meta_t            meta,
  output logic [CNT_W-1:0]       s1_count,
  output logic [WEIGHT_BITS-1:0] s1_weight,
  input  logic                   s1_take
);

  `include "assert_macros.svh"

  localparam int SUM_W = ((WEIGHT_BITS > ITEM_BITS) ? WEIGHT_BITS : ITEM_BITS) + 1;

  logic [WEIGHT_BITS-1:0] limit;
  logic [CNT_W-1:0]       count;
  logic [WEIGHT_BITS-1:0] weight_sum;
  logic                   pop_pend;

  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [SUM_W-1:0]       sum_ext;
  logic                   over;
  status_t                status;
  logic                   push_ok;
  logic                   pop_ok;
  logic [CNT_W-1:0]       count_next;
  logic [WEIGHT_BITS-1:0] weight_after_pop;

  assign cmd.ready = !pop_pend && (!meta.valid || s1_take);
  assign accept    = cmd.valid && cmd.ready;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign sum_ext = SUM_W'(weight_sum) + SUM_W'(cmd.item_value);
  assign over    = (sum_ext > SUM_W'(limit));

  always_comb begin
    if (cmd.command == CMD_POP) begin
      status = empty ? ST_EMPTY : ST_DONE;
    end else if (full) begin
      status = ST_FULL;
    end else if (over) begin
      status = ST_WEIGHT;
    end else begin
      status = ST_DONE;
    end
  end

  assign push_ok = accept && (cmd.command == CMD_PUSH) && (status == ST_DONE);
  assign pop_ok  = accept && (cmd.command == CMD_POP) && (status == ST_DONE);

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // popped weight is subtracted once the store returns the item
  always_comb begin
    if (SUM_W'(weight_sum) >= SUM_W'(rd_data)) begin
      weight_after_pop = WEIGHT_BITS'(SUM_W'(weight_sum) - SUM_W'(rd_data));
    end else begin
      weight_after_pop = '0;
    end
  end

  assign store_ctl.wr_en = push_ok;
  assign store_ctl.rd_en = pop_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= LIMIT_RESET;
      count      <= '0;
      weight_sum <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      pop_pend   <= 1'b0;
      meta.valid <= 1'b0;
    end else begin
      if (limit_we) begin
        limit <= limit_wdata;
      end
      count    <= count_next;
      pop_pend <= pop_ok;
      if (push_ok) begin
        weight_sum <= sum_ext[WEIGHT_BITS-1:0];
        wr_ptr     <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end else if (pop_pend) begin
        weight_sum <= weight_after_pop;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if ((accept && !pop_ok) || pop_pend) begin
        meta.valid <= 1'b1;
      end else if (s1_take) begin
        meta.valid <= 1'b0;
      end
      if (accept) begin
        meta.status <= status;
        meta.pop_ok <= pop_ok;
        s1_count    <= count_next;
        s1_weight   <= push_ok ? sum_ext[WEIGHT_BITS-1:0] : weight_sum;
      end else if (pop_pend) begin
        s1_weight <= weight_after_pop;
      end
    end
  end

  `WLF_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `WLF_ASSERT_IMP(a_pend_blocks, clk, rst, pop_pend, !cmd.ready)
  `WLF_ASSERT_NXT(a_pend_loads, clk, rst, pop_pend, meta.valid && meta.pop_ok)
  `WLF_ASSERT_NXT(a_push_count, clk, rst, push_ok, count == $past(count) + CNT_W'(1))

endmodule

/* rtl/wlf_out.sv */
// Output register: holds the response beat until the sink takes it
`timescale 1ns / 1ps

module wlf_out
  import wlf_pkg::*;
#(
  parameter int ITEM_BITS = 8,
  parameter int CNT_W     = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_meta_t            meta,
  input  logic [CNT_W-1:0]       s1_count,
  input  logic [WEIGHT_BITS-1:0] s1_weight,
  input  logic [ITEM_BITS-1:0]   rd_data,
  output logic                   s1_take,
  wlf_rsp_if.source              rsp
);

  assign s1_take = meta.valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      rsp.status       <= meta.status;
      rsp.popped_value <= meta.pop_ok ? rd_data : '0;
      rsp.entry_count  <= s1_count;
      rsp.total_weight <= s1_weight;
    end
  end

endmodule

/* rtl/weight_limited_fifo.sv */
// Top level: weight-limited FIFO with status per command
`timescale 1ns / 1ps

// A FIFO of DEPTH items whose value is also its weight. Every command beat
// (push or pop) returns exactly one response beat with a status, the popped
// item (zero unless a pop succeeded), the entry count and the held weight.
// A push is refused when full (status full wins) or when the held weight plus
// the item would exceed weight_limit; a pop is refused when empty. Pushes and
// refused commands are taken one per cycle unless the response side stalls.
// A successful pop blocks the next command while pending; its item comes
// from the store's read register in the cycle after issue and its weight is
// subtracted then. The response register lets the next command enter while
// an earlier response waits. weight_limit resets to 32 and is written through
// limit_we / limit_wdata only while the block is idle; the user ensures this.
module weight_limited_fifo
  import wlf_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int ITEM_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   limit_we,
  input  logic [WEIGHT_BITS-1:0] limit_wdata,
  wlf_cmd_if.sink                cmd,
  wlf_rsp_if.source              rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  store_ctl_t             store_ctl;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [ITEM_BITS-1:0]   rd_data;
  stage_meta_t            meta;
  logic [CNT_W-1:0]       s1_count;
  logic [WEIGHT_BITS-1:0] s1_weight;
  logic                   s1_take;

  wlf_store #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .wr_addr (wr_ptr),
    .rd_addr (rd_ptr),
    .wr_data (cmd.item_value),
    .rd_data (rd_data)
  );

  wlf_ctrl #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata),
    .cmd         (cmd),
    .store_ctl   (store_ctl),
    .wr_ptr      (wr_ptr),
    .rd_ptr      (rd_ptr),
    .rd_data     (rd_data),
    .meta        (meta),
    .s1_count    (s1_count),
    .s1_weight   (s1_weight),
    .s1_take     (s1_take)
  );

  wlf_out #(
    .ITEM_BITS (ITEM_BITS),
    .CNT_W     (CNT_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .meta      (meta),
    .s1_count  (s1_count),
    .s1_weight (s1_weight),
    .rd_data   (rd_data),
    .s1_take   (s1_take),
    .rsp       (rsp)
  );

endmodule

/* tb/tb_weight_limited_fifo.sv */
// Testbench: random and directed push/pop traffic checked against a scoreboard
`timescale 1ns / 1ps

module tb_weight_limited_fifo;
  import wlf_pkg::*;

  localparam int FIFO_DEPTH  = 64;
  localparam int ITEM_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_STALL  = 200;

  typedef struct {
    status_t                status;
    logic [ITEM_W-1:0]      popped;
    logic [COUNT_W-1:0]     count;
    logic [WEIGHT_BITS-1:0] weight;
  } fifo_reply_t;

  // Tracks FIFO contents and weight; queues the reply each command should get
  class weight_book;
    logic [ITEM_W-1:0]      slots [FIFO_DEPTH];
    logic [5:0]             rd_ptr;
    logic [5:0]             wr_ptr;
    logic [COUNT_W-1:0]     held;
    logic [WEIGHT_BITS-1:0] weight_sum;
    logic [WEIGHT_BITS-1:0] weight_limit;
    fifo_reply_t            replies [$];
    int unsigned            fails;

    function new();
      rd_ptr       = '0;
      wr_ptr       = '0;
      held         = '0;
      weight_sum   = '0;
      weight_limit = LIMIT_RESET;
      fails        = 0;
    endfunction

    function void note_command(input logic cmd, input logic [ITEM_W-1:0] value);
      fifo_reply_t r;
      r.status = ST_DONE;
      r.popped = '0;
      if (cmd == CMD_PUSH) begin
        // full takes priority over overweight
        if (held >= FIFO_DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(weight_sum) + int'(value) > int'(weight_limit)) begin
          r.status = ST_WEIGHT;
        end else begin
          slots[wr_ptr] = value;
          wr_ptr        = wr_ptr + 1'b1;
          weight_sum    = weight_sum + value;
          held          = held + 1'b1;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped   = slots[rd_ptr];
        rd_ptr     = rd_ptr + 1'b1;
        weight_sum = weight_sum - r.popped;
        held       = held - 1'b1;
      end
      r.count  = held;
      r.weight = weight_sum;
      replies.push_back(r);
    endfunction

    function void check_reply(input fifo_reply_t got);
      fifo_reply_t want;
      if (replies.size() == 0) begin
        fails++;
        $display("%0t: reply beat with no command outstanding", $time);
        return;
      end
      want = replies.pop_front();
      if (got.status !== want.status) begin
        fails++;
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.popped !== want.popped) begin
        fails++;
        $display("%0t: popped_value expected %0d, got %0d", $time, want.popped, got.popped);
      end
      if (got.count !== want.count) begin
        fails++;
        $display("%0t: entry_count expected %0d, got %0d", $time, want.count, got.count);
      end
      if (got.weight !== want.weight) begin
        fails++;
        $display("%0t: total_weight expected %0d, got %0d", $time, want.weight, got.weight);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   limit_we;
  logic [WEIGHT_BITS-1:0] limit_wdata;

  wlf_cmd_if #(.ITEM_BITS(ITEM_W)) cmd_bus ();
  wlf_rsp_if #(.ITEM_BITS(ITEM_W), .COUNT_BITS(COUNT_W)) rsp_bus ();

  weight_book sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req     = 0;
  int quiet_cycles  = 0;

  weight_limited_fifo #(
    .DEPTH    (FIFO_DEPTH),
    .ITEM_BITS(ITEM_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .limit_we   (limit_we),
    .limit_wdata(limit_wdata),
    .cmd        (cmd_bus),
    .rsp        (rsp_bus)
  );

  always #1 clk = ~clk;

  // Reply sink: random stalls plus an occasional long hold-off on request
  initial begin : reply_sink
    int hold;
    hold          = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req > 0) begin
        hold      = stall_req;
        stall_req = 0;
      end
      if (hold > 0) begin
        rsp_bus.ready <= 1'b0;
        hold--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Both channels sampled at the edge; reply is checked before the new command is noted
  always @(posedge clk) begin : beat_monitor
    fifo_reply_t got;
    logic        moved;
    moved = 1'b0;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.status = rsp_bus.status;
        got.popped = rsp_bus.popped_value;
        got.count  = rsp_bus.entry_count;
        got.weight = rsp_bus.total_weight;
        sb.check_reply(got);
        moved = 1'b1;
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        sb.note_command(cmd_bus.command, cmd_bus.item_value);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_cmd(input logic cmd, input logic [ITEM_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid      <= 1'b0;
      cmd_bus.command    <= 1'($urandom);
      cmd_bus.item_value <= ITEM_W'($urandom);
      @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= cmd;
    cmd_bus.item_value <= value;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Stop sending and wait until every reply is back and the pipe is empty
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [WEIGHT_BITS-1:0] value);
    limit_we    <= 1'b1;
    limit_wdata <= value;
    @(posedge clk);
    limit_we        <= 1'b0;
    sb.weight_limit = value;
  endtask

  // light: weights small enough that the count limit is reached before the weight limit
  function automatic logic [ITEM_W-1:0] pick_value(input bit light);
    int room;
    int cap;
    room = int'(sb.weight_limit) - int'(sb.weight_sum);
    cap  = int'(sb.weight_limit) / FIFO_DEPTH;
    if (cap > 255) cap = 255;
    if (light) return ITEM_W'($urandom_range(cap));
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: if (room >= 0 && room < 256) return ITEM_W'(room);
      3: if (room >= -1 && room < 255) return ITEM_W'(room + 1);
      4, 5: return ITEM_W'($urandom_range(cap));
      default: ;
    endcase
    return ITEM_W'($urandom);
  endfunction

  // Bursts: fill runs, drain runs past empty, and mixed traffic
  task automatic run_segment(input int quota);
    int sent;
    int len;
    int kind;
    int push_pct;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        len      = $urandom_range(90, 70);
        push_pct = 100;
      end else if (kind < 4) begin
        len      = $urandom_range(90, 70);
        push_pct = 0;
      end else begin
        len      = $urandom_range(40, 10);
        push_pct = $urandom_range(70, 40);
      end
      repeat (len) begin
        if ($urandom_range(99) < push_pct) begin
          send_cmd(CMD_PUSH, pick_value(kind < 2 && $urandom_range(3) != 0));
        end else begin
          send_cmd(CMD_POP, ITEM_W'($urandom));
        end
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    logic [WEIGHT_BITS-1:0] lim;
    rst                = 1'b1;
    limit_we           = 1'b0;
    limit_wdata        = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = CMD_PUSH;
    cmd_bus.item_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset limit of 32: exact fit, overweight, zero weight at the limit, empty pop
    send_cmd(CMD_POP, 8'hFF);
    send_cmd(CMD_PUSH, 8'd0);
    send_cmd(CMD_PUSH, 8'd32);
    send_cmd(CMD_PUSH, 8'd1);
    send_cmd(CMD_PUSH, 8'd0);
    send_cmd(CMD_PUSH, 8'd255);
    send_cmd(CMD_POP, 8'h00);
    send_cmd(CMD_POP, 8'h5A);
    send_cmd(CMD_POP, 8'hA5);
    send_cmd(CMD_POP, 8'hFF);
    settle();

    write_limit('1);
    send_cmd(CMD_PUSH, 8'd255);
    send_cmd(CMD_PUSH, 8'd200);
    send_cmd(CMD_PUSH, 8'hAA);
    send_cmd(CMD_PUSH, 8'h55);
    settle();

    // limit drops below the held weight: pops still work, every push is refused
    write_limit(14'd100);
    send_cmd(CMD_PUSH, 8'd0);
    send_cmd(CMD_PUSH, 8'd1);
    send_cmd(CMD_POP, 8'd0);
    send_cmd(CMD_PUSH, 8'd1);
    repeat (5) send_cmd(CMD_POP, ITEM_W'($urandom));

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: lim = '0;
        1: lim = WEIGHT_BITS'($urandom_range(2000, 16));
        2: lim = '1;
        3: lim = WEIGHT_BITS'($urandom_range(255, 1));
        4: lim = WEIGHT_BITS'($urandom_range(16383));
        default: lim = 14'd32;
      endcase
      settle();
      send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 84 : 0;
      recv_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 12 : 0;
      write_limit(lim);
      run_segment(130);
      if (seg == 5) begin
        // long reply hold-off while commands keep coming, so input backs up
        stall_req = LONG_STALL;
        repeat (40) send_cmd(CMD_PUSH, pick_value(1'b0));
        settle();
        repeat (20) send_cmd($urandom_range(1) ? CMD_POP : CMD_PUSH, pick_value(1'b0));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
